/* rtl/core/ihdk_pkg.sv */
// Shared constants, types and codes of the indexed min-heap block.
package ihdk_pkg;

	localparam int CAPACITY = 1024;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = SLOT_W + 1;
	localparam int ID_W     = 10;
	localparam int ITEMS    = 1 << ID_W;
	localparam int KEY_BITS = 32;
	localparam int KEY_IN_W = 32;
	localparam int STAT_W   = 3;

	typedef enum logic [1:0] {
		KIND_PUSH  = 2'd0,
		KIND_POP   = 2'd1,
		KIND_DECR  = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 3'd0,
		STAT_EMPTY   = 3'd1,
		STAT_FULL    = 3'd2,
		STAT_IGNORED = 3'd3,
		STAT_DUP     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_LOOK_SLOT,
		ST_LOOK_HEAP,
		ST_UP_RD,
		ST_UP_CMP,
		ST_POP_TOP,
		ST_POP_MOV,
		ST_DN_L,
		ST_DN_R,
		ST_DN_CMP,
		ST_FINISH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic [KEY_BITS-1:0] key;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		status_t             status;
		logic [ID_W-1:0]     popped_index;
		logic [KEY_BITS-1:0] popped_key;
		logic [CNT_W-1:0]    entry_count;
		logic                is_empty;
	} result_t;

endpackage

/* rtl/core/indexed_min_heap_decrease_key.sv */
// Top level of the indexed binary min-heap with decrease-key and its result register.
//
// This block keeps a binary min-heap of up to 1024 (item index, key) words together
// with a map from item index to heap slot, and serves four operations: push, pop of
// the minimum, decrease-key and clear. Each accepted input word yields exactly one
// result word with a status code, the popped pair on a successful pop and the entry
// count afterwards. The heap entries live in one synchronous RAM and the slot map in
// a second; the sequencer reads, compares and writes back one tree level at a time,
// holding the moving entry in a register and writing it once at its final slot.
// Presence of an item is decided by checking that its mapped slot is below the count
// and that the heap entry there carries the same index, so clear only resets the count.
// Operations are served one at a time; no word is taken while one is in progress.
// After reset every entry of the slot map is cleared to zero, during which in_stall
// stays high. The result register lets the next word be taken while a finished
// result still waits.
module indexed_min_heap_decrease_key
	import ihdk_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          kind,
	input  logic [ID_W-1:0]     item_index,
	input  logic [KEY_IN_W-1:0] item_key,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STAT_W-1:0]   status,
	output logic [ID_W-1:0]     popped_index,
	output logic [KEY_IN_W-1:0] popped_key,
	output logic [CNT_W-1:0]    entry_count,
	output logic                is_empty
);

	logic              h_we;
	logic [SLOT_W-1:0] h_waddr;
	entry_t            h_wdata;
	logic [SLOT_W-1:0] h_raddr;
	entry_t            h_rdata;
	logic              s_we;
	logic [ID_W-1:0]   s_waddr;
	logic [SLOT_W-1:0] s_wdata;
	logic [ID_W-1:0]   s_raddr;
	logic [SLOT_W-1:0] s_rdata;
	logic              res_valid;
	logic              res_ready;
	result_t           res;
	result_t           out_q;
	logic              out_valid_q;

	// The heap entries, one (index, key) word per slot.
	ihdk_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_heap_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	// The slot map, one heap slot per item index.
	ihdk_ram #(.WIDTH(SLOT_W), .DEPTH(ITEMS)) u_slot_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	ihdk_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.item_index (item_index),
		.item_key   (item_key),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.h_we       (h_we),
		.h_waddr    (h_waddr),
		.h_wdata    (h_wdata),
		.h_raddr    (h_raddr),
		.h_rdata    (h_rdata),
		.s_we       (s_we),
		.s_waddr    (s_waddr),
		.s_wdata    (s_wdata),
		.s_raddr    (s_raddr),
		.s_rdata    (s_rdata)
	);

	// The result register is free when empty or when its word leaves this cycle.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign popped_index = out_q.popped_index;
	assign popped_key   = KEY_IN_W'(out_q.popped_key);
	assign entry_count  = out_q.entry_count;
	assign is_empty     = out_q.is_empty;

endmodule

/* rtl/core/ihdk_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module ihdk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/ihdk_ctrl.sv */
// Operation sequencer: lookup, sift up and sift down over the heap and slot memories.
module ihdk_ctrl
	import ihdk_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          kind,
	input  logic [ID_W-1:0]     item_index,
	input  logic [KEY_IN_W-1:0] item_key,
	output logic                res_valid,
	input  logic                res_ready,
	output result_t             res,
	output logic                h_we,
	output logic [SLOT_W-1:0]   h_waddr,
	output entry_t              h_wdata,
	output logic [SLOT_W-1:0]   h_raddr,
	input  entry_t              h_rdata,
	output logic                s_we,
	output logic [ID_W-1:0]     s_waddr,
	output logic [SLOT_W-1:0]   s_wdata,
	output logic [ID_W-1:0]     s_raddr,
	input  logic [SLOT_W-1:0]   s_rdata
);

	localparam int WIDE_W = SLOT_W + 2;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    count_q;
	logic [SLOT_W-1:0]   sweep_q;
	kind_t               kind_q;
	logic [ID_W-1:0]     idx_q;
	logic [KEY_BITS-1:0] key_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SLOT_W-1:0]   hole_q;
	entry_t              mov_q;
	entry_t              child_q;
	entry_t              pop_q;
	status_t             status_q;
	logic                pop_ok_q;

	logic                accept;
	logic [SLOT_W-1:0]   parent;
	logic [WIDE_W-1:0]   lchild;
	logic [WIDE_W-1:0]   rchild;
	logic [WIDE_W-1:0]   count_w;
	logic                l_ok;
	logic                r_ok;
	logic                present;
	logic                up_move;
	entry_t              best;
	logic [SLOT_W-1:0]   best_slot;
	logic                dn_move;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	assign parent  = SLOT_W'((hole_q - SLOT_W'(1)) >> 1);
	assign lchild  = {1'b0, hole_q, 1'b1};
	assign rchild  = lchild + WIDE_W'(1);
	assign count_w = WIDE_W'(count_q);
	assign l_ok    = lchild < count_w;
	assign r_ok    = rchild < count_w;
	assign present = (CNT_W'(slot_q) < count_q) && (h_rdata.id == idx_q);
	assign up_move = mov_q.key < h_rdata.key;
	assign best      = (r_ok && (h_rdata.key < child_q.key)) ? h_rdata : child_q;
	assign best_slot = (r_ok && (h_rdata.key < child_q.key)) ? rchild[SLOT_W-1:0]
		: lchild[SLOT_W-1:0];
	assign dn_move = best.key < mov_q.key;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_SWEEP: begin
				if (sweep_q == SLOT_W'(CAPACITY - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (kind_t'(kind))
						KIND_PUSH, KIND_DECR: state_d = ST_LOOK_SLOT;
						KIND_POP:  state_d = (count_q == '0) ? ST_DONE : ST_POP_TOP;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_LOOK_SLOT: state_d = ST_LOOK_HEAP;
			ST_LOOK_HEAP: begin
				if (kind_q == KIND_PUSH) begin
					state_d = (present || count_q == CNT_W'(CAPACITY)) ? ST_DONE : ST_UP_RD;
				end else begin
					state_d = (!present || h_rdata.key <= key_q) ? ST_DONE : ST_UP_RD;
				end
			end
			ST_UP_RD:   state_d = (hole_q == '0) ? ST_FINISH : ST_UP_CMP;
			ST_UP_CMP:  state_d = up_move ? ST_UP_RD : ST_FINISH;
			ST_POP_TOP: state_d = ST_POP_MOV;
			ST_POP_MOV: state_d = ST_DN_L;
			ST_DN_L:    state_d = l_ok ? ST_DN_R : ST_FINISH;
			ST_DN_R:    state_d = ST_DN_CMP;
			ST_DN_CMP:  state_d = dn_move ? ST_DN_L : ST_FINISH;
			ST_FINISH:  state_d = ST_DONE;
			ST_DONE:    state_d = res_ready ? ST_IDLE : ST_DONE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Memory controls.
	always_comb begin
		h_we    = 1'b0;
		h_waddr = hole_q;
		h_wdata = mov_q;
		h_raddr = '0;
		s_we    = 1'b0;
		s_waddr = mov_q.id;
		s_wdata = hole_q;
		s_raddr = item_index;
		case (state_q)
			ST_SWEEP: begin
				s_we    = 1'b1;
				s_waddr = ID_W'(sweep_q);
				s_wdata = '0;
			end
			ST_LOOK_SLOT: h_raddr = s_rdata;
			ST_UP_RD:     h_raddr = parent;
			ST_UP_CMP: begin
				if (up_move) begin
					h_we    = 1'b1;
					h_wdata = h_rdata;
					s_we    = 1'b1;
					s_waddr = h_rdata.id;
				end
			end
			ST_POP_TOP: h_raddr = SLOT_W'(count_q - CNT_W'(1));
			ST_DN_L:    h_raddr = lchild[SLOT_W-1:0];
			ST_DN_R:    h_raddr = rchild[SLOT_W-1:0];
			ST_DN_CMP: begin
				if (dn_move) begin
					h_we    = 1'b1;
					h_wdata = best;
					s_we    = 1'b1;
					s_waddr = best.id;
				end
			end
			ST_FINISH: begin
				h_we = 1'b1;
				s_we = 1'b1;
			end
			default: ;
		endcase
	end

	assign res_valid        = (state_q == ST_DONE);
	assign res.status       = status_q;
	assign res.popped_index = pop_ok_q ? pop_q.id : '0;
	assign res.popped_key   = pop_ok_q ? pop_q.key : '0;
	assign res.entry_count  = count_q;
	assign res.is_empty     = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_SWEEP;
			count_q  <= '0;
			sweep_q  <= '0;
			status_q <= STAT_OK;
			pop_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_SWEEP: sweep_q <= sweep_q + SLOT_W'(1);
				ST_IDLE: begin
					if (accept) begin
						kind_q   <= kind_t'(kind);
						idx_q    <= item_index;
						key_q    <= KEY_BITS'(item_key);
						status_q <= (kind_t'(kind) == KIND_POP && count_q == '0) ?
							STAT_EMPTY : STAT_OK;
						pop_ok_q <= 1'b0;
						if (kind_t'(kind) == KIND_CLEAR) count_q <= '0;
					end
				end
				ST_LOOK_SLOT: slot_q <= s_rdata;
				ST_LOOK_HEAP: begin
					mov_q.id  <= idx_q;
					mov_q.key <= key_q;
					if (kind_q == KIND_PUSH) begin
						if (present) begin
							status_q <= STAT_DUP;
						end else if (count_q == CNT_W'(CAPACITY)) begin
							status_q <= STAT_FULL;
						end else begin
							hole_q  <= SLOT_W'(count_q);
							count_q <= count_q + CNT_W'(1);
						end
					end else begin
						if (!present || h_rdata.key <= key_q) begin
							status_q <= STAT_IGNORED;
						end else begin
							hole_q <= slot_q;
						end
					end
				end
				ST_UP_CMP: if (up_move) hole_q <= parent;
				ST_POP_TOP: begin
					pop_q    <= h_rdata;
					pop_ok_q <= 1'b1;
					count_q  <= count_q - CNT_W'(1);
				end
				ST_POP_MOV: begin
					mov_q  <= h_rdata;
					hole_q <= '0;
				end
				ST_DN_R:   child_q <= h_rdata;
				ST_DN_CMP: if (dn_move) hole_q <= best_slot;
				default: ;
			endcase
		end
	end

endmodule

/* tb/tb_indexed_min_heap_decrease_key.sv */
// Self-checking testbench of the indexed min-heap with decrease-key.
`timescale 1ns / 1ps

module tb_indexed_min_heap_decrease_key
	import ihdk_pkg::*;
();

	// Clock, reset and the two handshake channels.
	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          kind;
	logic [ID_W-1:0]     item_index;
	logic [KEY_IN_W-1:0] item_key;
	logic                out_valid;
	logic                out_stall;
	logic [STAT_W-1:0]   status;
	logic [ID_W-1:0]     popped_index;
	logic [KEY_IN_W-1:0] popped_key;
	logic [CNT_W-1:0]    entry_count;
	logic                is_empty;

	indexed_min_heap_decrease_key dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .item_index(item_index), .item_key(item_key),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .popped_index(popped_index), .popped_key(popped_key),
		.entry_count(entry_count), .is_empty(is_empty)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// The predictor keeps its own heap: keys and ids per slot, plus a slot map
	// and a present flag per item, exactly as the block should see them.
	logic [KEY_BITS-1:0] shadow_key [CAPACITY];
	logic [ID_W-1:0]     shadow_id  [CAPACITY];
	int unsigned         slot_map   [ITEMS];
	bit                  present    [ITEMS];
	int unsigned         heap_size;

	// Expected result words, oldest first.
	result_t expected_q[$];

	int  mismatches;
	longint cycle_count;

	// Random idling on both sides; a quiet window turns idling off for a while,
	// and a hold-off window makes the receiver stall for a long stretch.
	bit quiet;
	bit hold_off;

	// Directed table: a typed expectation is used when has_exp is set.
	typedef struct {
		kind_t               k;
		logic [ID_W-1:0]     idx;
		logic [KEY_IN_W-1:0] key;
		bit                  has_exp;
		result_t             exp;
	} vector_t;

	function automatic void swap_entries(int unsigned a, int unsigned b);
		logic [KEY_BITS-1:0] tk;
		logic [ID_W-1:0]     ti;
		tk = shadow_key[a]; ti = shadow_id[a];
		shadow_key[a] = shadow_key[b]; shadow_id[a] = shadow_id[b];
		shadow_key[b] = tk; shadow_id[b] = ti;
		slot_map[shadow_id[a]] = a;
		slot_map[shadow_id[b]] = b;
	endfunction

	function automatic void climb(int unsigned at);
		int unsigned up;
		while (at != 0) begin
			up = (at - 1) / 2;
			if (shadow_key[at] >= shadow_key[up]) break;
			swap_entries(at, up);
			at = up;
		end
	endfunction

	function automatic void descend(int unsigned at);
		int unsigned best, l, r;
		while (at < heap_size) begin
			best = at; l = 2 * at + 1; r = 2 * at + 2;
			if (l < heap_size && shadow_key[l] < shadow_key[best]) best = l;
			if (r < heap_size && shadow_key[r] < shadow_key[best]) best = r;
			if (best == at) break;
			swap_entries(at, best);
			at = best;
		end
	endfunction

	// Applies one operation to the predictor and returns the word it must produce.
	function automatic result_t heap_apply(kind_t k, logic [ID_W-1:0] idx,
			logic [KEY_IN_W-1:0] key);
		result_t     r;
		int unsigned s;
		logic [ID_W-1:0] top;
		r = '0;
		r.status = STAT_OK;
		case (k)
			KIND_PUSH: begin
				if (present[idx]) r.status = STAT_DUP;
				else if (heap_size >= CAPACITY) r.status = STAT_FULL;
				else begin
					s = heap_size;
					shadow_key[s] = key; shadow_id[s] = idx;
					slot_map[idx] = s; present[idx] = 1'b1;
					heap_size = s + 1;
					climb(s);
				end
			end
			KIND_POP: begin
				if (heap_size == 0) r.status = STAT_EMPTY;
				else begin
					top = shadow_id[0];
					r.popped_index = top;
					r.popped_key = shadow_key[0];
					heap_size--;
					shadow_key[0] = shadow_key[heap_size];
					shadow_id[0] = shadow_id[heap_size];
					slot_map[shadow_id[0]] = 0;
					descend(0);
					present[top] = 1'b0;
				end
			end
			KIND_DECR: begin
				s = slot_map[idx];
				if (!present[idx] || s >= heap_size || shadow_key[s] <= key)
					r.status = STAT_IGNORED;
				else begin
					shadow_key[s] = key;
					climb(s);
					descend(slot_map[idx]);
				end
			end
			default: begin
				heap_size = 0;
				foreach (present[i]) present[i] = 1'b0;
			end
		endcase
		r.entry_count = heap_size[CNT_W-1:0];
		r.is_empty = (heap_size == 0);
		return r;
	endfunction

	// Offers one word and holds it until the block takes it; the predictor
	// is run here so that expectations stay in acceptance order. Valid stays
	// high after acceptance until the next word or an idle cycle replaces it.
	task automatic send_word(kind_t k, logic [ID_W-1:0] idx, logic [KEY_IN_W-1:0] key,
			bit has_exp, result_t exp);
		result_t r;
		while (!quiet && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		item_index <= idx;
		item_key   <= key;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = heap_apply(k, idx, key);
		if (has_exp && r != exp)
			$display("directed row disagrees with predictor: %p vs %p", exp, r);
		expected_q.push_back(has_exp ? exp : r);
	endtask

	// Builds an expectation word for the table.
	function automatic result_t mk(status_t st, int cnt);
		result_t r;
		r = '0;
		r.status = st;
		r.entry_count = cnt[CNT_W-1:0];
		r.is_empty = (cnt == 0);
		return r;
	endfunction

	// Receiver side: random stalls, a long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= hold_off || (!quiet && $urandom_range(99) < 14);
		end
	end

	// Checker: every accepted result word against the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: status %0d count %0d",
						status, entry_count);
			end else begin
				want = expected_q.pop_front();
				if (status !== want.status || popped_index !== want.popped_index ||
						popped_key !== want.popped_key ||
						entry_count !== want.entry_count || is_empty !== want.is_empty) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%0d/%h/%0d/%0d, got %0d/%0d/%h/%0d/%0d",
							want.status, want.popped_index, want.popped_key,
							want.entry_count, want.is_empty, status, popped_index,
							popped_key, entry_count, is_empty);
				end
			end
		end
	end

	// Watchdog: the slowest legal run ends well before this limit is reached.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 400000) begin
			$display("indexed_min_heap_decrease_key verification failed");
			$finish;
		end
	end

	// Long receiver hold-off, counted in its own process, while words keep coming.
	task automatic hold_receiver(int cycles);
		hold_off = 1'b1;
		repeat (cycles) @(posedge clk);
		hold_off = 1'b0;
	endtask

	// Picks an item index that is currently in the heap, or a random one.
	function automatic logic [ID_W-1:0] live_index();
		if (heap_size == 0) return ID_W'($urandom_range(ITEMS - 1));
		return shadow_id[$urandom_range(heap_size - 1)];
	endfunction

	vector_t dir [$];
	result_t none;

	initial begin
		logic [ID_W-1:0]     idx;
		logic [KEY_IN_W-1:0] key;
		int unsigned         roll;
		kind_t               k;
		result_t             pop_exp;

		mismatches = 0; cycle_count = 0; quiet = 1'b0; hold_off = 1'b0;
		heap_size = 0;
		foreach (present[i]) present[i] = 1'b0;
		foreach (slot_map[i]) slot_map[i] = 0;
		none = '0;
		in_valid = 1'b0; kind = KIND_PUSH; item_index = '0; item_key = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows: empty pop, extreme keys and indexes, duplicates,
		// ignored decreases, and a clear.
		pop_exp = mk(STAT_OK, 1);
		pop_exp.popped_index = 10'd1023;
		pop_exp.popped_key = 32'h0;
		dir = '{
			'{KIND_POP,   10'd0,    32'h0,        1, mk(STAT_EMPTY, 0)},
			'{KIND_DECR,  10'd5,    32'h0,        1, mk(STAT_IGNORED, 0)},
			'{KIND_PUSH,  10'd0,    32'hFFFFFFFF, 1, mk(STAT_OK, 1)},
			'{KIND_PUSH,  10'd0,    32'h1,        1, mk(STAT_DUP, 1)},
			'{KIND_PUSH,  10'd1023, 32'h0,        1, mk(STAT_OK, 2)},
			'{KIND_POP,   10'd0,    32'h0,        1, pop_exp},
			'{KIND_PUSH,  10'd512,  32'h80000000, 0, none},
			'{KIND_PUSH,  10'd341,  32'h55555555, 0, none},
			'{KIND_PUSH,  10'd682,  32'hAAAAAAAA, 0, none},
			'{KIND_DECR,  10'd682,  32'hAAAAAAAA, 1, mk(STAT_IGNORED, 4)},
			'{KIND_DECR,  10'd682,  32'hFFFFFFFF, 1, mk(STAT_IGNORED, 4)},
			'{KIND_DECR,  10'd0,    32'h7FFFFFFF, 0, none},
			'{KIND_DECR,  10'd682,  32'h00000001, 0, none},
			'{KIND_POP,   10'd0,    32'h0,        0, none},
			'{KIND_POP,   10'd0,    32'h0,        0, none},
			'{KIND_DECR,  10'd682,  32'h0,        1, mk(STAT_IGNORED, 2)},
			'{KIND_CLEAR, 10'd0,    32'h0,        1, mk(STAT_OK, 0)},
			'{KIND_DECR,  10'd0,    32'h0,        1, mk(STAT_IGNORED, 0)},
			'{KIND_POP,   10'd0,    32'h0,        1, mk(STAT_EMPTY, 0)},
			'{KIND_PUSH,  10'd0,    32'h12345678, 1, mk(STAT_OK, 1)}
		};
		foreach (dir[i]) send_word(dir[i].k, dir[i].idx, dir[i].key,
			dir[i].has_exp, dir[i].exp);

		// Random part: mostly pushes and pops on a live heap, decreases mostly aimed at
		// items that are present, rare clears. A later phase fills the heap to its
		// capacity so that a duplicate push on a full heap is reached.
		for (int n = 0; n < 80; n++) begin
			if (n == 20) quiet = 1'b1;
			if (n == 50) quiet = 1'b0;
			if (n == 55) fork hold_receiver(300); join_none
			roll = $urandom_range(99);
			key = $urandom();
			if ($urandom_range(7) == 0) key = $urandom_range(15);
			if (roll < 45) begin
				k = KIND_PUSH;
				idx = ($urandom_range(9) == 0) ? live_index()
					: ID_W'($urandom_range(ITEMS - 1));
			end else if (roll < 75) begin
				k = KIND_POP; idx = ID_W'($urandom_range(ITEMS - 1));
			end else if (roll < 98) begin
				k = KIND_DECR;
				idx = ($urandom_range(4) == 0) ? ID_W'($urandom_range(ITEMS - 1))
					: live_index();
				if (heap_size != 0 && $urandom_range(1) == 0)
					key = shadow_key[slot_map[idx]] >> $urandom_range(3);
			end else begin
				k = KIND_CLEAR; idx = ID_W'($urandom_range(ITEMS - 1));
			end
			send_word(k, idx, key, 1'b0, none);
		end

		// Fill to capacity with distinct items, push a duplicate once more, then decrease and pop.
		send_word(KIND_CLEAR, '0, '0, 1'b0, none);
		for (int i = 0; i < ITEMS; i++)
			send_word(KIND_PUSH, i[ID_W-1:0], $urandom(), 1'b0, none);
		send_word(KIND_PUSH, 10'd7, 32'h0, 1'b1, mk(STAT_DUP, CAPACITY));
		for (int i = 0; i < 40; i++)
			send_word(KIND_DECR, live_index(), $urandom_range(255), 1'b0, none);
		for (int i = 0; i < 60; i++)
			send_word(KIND_POP, '0, '0, 1'b0, none);
		in_valid <= 1'b0;

		// Drain, then allow the block's worst latency to pass.
		while (expected_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("indexed_min_heap_decrease_key verification clean");
		end else begin
			$display("indexed_min_heap_decrease_key verification failed");
		end
		$finish;
	end

endmodule

/* indexed_min_heap_decrease_key.f */
rtl/core/ihdk_pkg.sv
rtl/core/ihdk_ram.sv
rtl/core/ihdk_ctrl.sv
rtl/core/indexed_min_heap_decrease_key.sv
tb/tb_indexed_min_heap_decrease_key.sv
